// File: rtl/scrle_pkg.sv
// ----------------------------------------------------------------------------
// scrle_pkg
// Types and constants shared by the column run-length sprite decoder.
// ----------------------------------------------------------------------------
package scrle_pkg;

	// Rows a column may hold; the row counter saturates below this.
	localparam int unsigned MAX_ROWS = 4096;
	localparam int unsigned ROW_W    = 12;
	localparam int unsigned ROW_TOP_INT = (MAX_ROWS - 1 > 4095) ? 4095 : MAX_ROWS - 1;
	localparam logic [ROW_W-1:0] ROW_TOP = ROW_TOP_INT[ROW_W-1:0];

	// Control byte of 128: neither a literal count nor a skip run.
	localparam logic [7:0] SKIP_BIAS = 8'd128;
	localparam logic [7:0] END_BYTE  = 8'd0;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        column_start;
		logic [11:0] column_index;
	} scrle_item_t;

	typedef struct packed {
		logic [11:0] out_column;
		logic [11:0] start_row;
		logic [6:0]  run_length;
		logic [7:0]  pixel_value;
		logic        is_transparent;
	} scrle_result_t;

endpackage

// File: rtl/sprite_column_rle_decoder_core.sv
// ----------------------------------------------------------------------------
// sprite_column_rle_decoder_core
// Decodes a column-wise run-length sprite stream, one byte per transaction.
// ----------------------------------------------------------------------------
// Takes one compressed byte per clock and turns it into at most one run: a
// single literal pixel or one transparent skip run, tagged with its column
// and its starting row counted from the column bottom. A byte is registered
// on acceptance, decoded in the following cycle against the column state,
// and its run lands in the result register. The sustained rate is one byte
// per cycle; the only thing that holds bytes back is a result register
// still waiting for the consumer, and bytes that give no run drain even
// while it waits.
module sprite_column_rle_decoder_core
	import scrle_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  scrle_item_t   item,
	output logic          result_valid,
	input  logic          result_ready,
	output scrle_result_t result
);

	// Input stage
	logic        valid_s1;
	scrle_item_t item_s1;

	// Column state
	logic [6:0]       literal_left_q;
	logic [ROW_W-1:0] row_count_q;
	logic             column_ended_q;

	// Result register
	logic          res_valid_q;
	scrle_result_t res_q;

	// Decode
	logic             first;
	logic [6:0]       lit_cur;
	logic [ROW_W-1:0] row_cur;
	logic             ended_cur;
	logic             has_result;
	scrle_result_t    res_d;
	logic [6:0]       lit_nxt;
	logic             ended_nxt;
	logic [6:0]       adv_len;
	logic [ROW_W:0]   row_sum;
	logic [ROW_W-1:0] row_nxt;
	logic             s1_go;

	// A new column clears the state before the byte is looked at.
	assign first     = item_s1.column_start;
	assign lit_cur   = first ? 7'd0 : literal_left_q;
	assign row_cur   = first ? '0 : row_count_q;
	assign ended_cur = first ? 1'b0 : column_ended_q;

	always_comb begin
		has_result = 1'b0;
		lit_nxt    = lit_cur;
		ended_nxt  = ended_cur;
		adv_len    = 7'd0;
		res_d.out_column     = item_s1.column_index;
		res_d.start_row      = row_cur;
		res_d.run_length     = 7'd1;
		res_d.pixel_value    = item_s1.data_byte;
		res_d.is_transparent = 1'b0;
		priority if (ended_cur) begin
			// rest of the column is ignored
		end else if (lit_cur != 7'd0) begin
			// literal pixel, byte 0 included
			has_result = 1'b1;
			lit_nxt    = lit_cur - 7'd1;
			adv_len    = 7'd1;
		end else if (item_s1.data_byte == END_BYTE) begin
			ended_nxt = 1'b1;
		end else if (!item_s1.data_byte[7]) begin
			lit_nxt = item_s1.data_byte[6:0];
		end else if (item_s1.data_byte == SKIP_BIAS) begin
			// no-op control byte
		end else begin
			has_result           = 1'b1;
			adv_len              = item_s1.data_byte[6:0];
			res_d.run_length     = item_s1.data_byte[6:0];
			res_d.pixel_value    = 8'd0;
			res_d.is_transparent = 1'b1;
		end
	end

	// Row advance, saturating at the top row
	assign row_sum = {1'b0, row_cur} + {{(ROW_W-6){1'b0}}, adv_len};
	assign row_nxt = (row_sum > {1'b0, ROW_TOP}) ? ROW_TOP : row_sum[ROW_W-1:0];

	// Byte in s1 retires when its run has somewhere to go, or it makes none.
	assign s1_go      = valid_s1 && (!has_result || !res_valid_q || result_ready);
	assign item_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			literal_left_q <= 7'd0;
			row_count_q    <= '0;
			column_ended_q <= 1'b0;
		end else if (s1_go) begin
			literal_left_q <= lit_nxt;
			row_count_q    <= row_nxt;
			column_ended_q <= ended_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && has_result) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && has_result) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// File: rtl/scrle_checker.sv
// ----------------------------------------------------------------------------
// scrle_checker
// Port-level checks for the column run-length decoder, bound to the top.
// ----------------------------------------------------------------------------
module scrle_checker
	import scrle_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	input logic          item_valid,
	input logic          item_ready,
	input logic          result_valid,
	input logic          result_ready,
	input scrle_result_t result
);

	// A run never covers zero pixels.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.run_length != 7'd0)
		else $error("empty run");

	// Literal pixels are one wide; skip runs carry palette index 0.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.is_transparent ? result.pixel_value == 8'd0
			: result.run_length == 7'd1))
		else $error("run kind and fields disagree");

	// Row counter saturates.
	a_row_top: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.start_row <= ROW_TOP)
		else $error("start row beyond top");

	// A run waiting for the consumer stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// A run that appears where none was must follow an accepted byte.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid ##1 result_valid |-> $past(item_valid && item_ready, 2))
		else $error("run without a byte");

endmodule

bind sprite_column_rle_decoder_core scrle_checker u_scrle_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
